// ===== design/ax25ui_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16 update for the AX.25 UI frame builder.
// Used by ax25ui_addr_byte, ax25_ui_frame_builder and its testbench; depends on nothing else.
package ax25ui_pkg;

    localparam int          MaxLeadFlags = 32;
    localparam int          FlagCountW   = 6;
    localparam int          CallW        = 48;
    localparam int          SsidW        = 4;
    localparam int          CfgIndexW    = 3;

    localparam logic [7:0]  FlagByte   = 8'h7E;
    localparam logic [7:0]  CtrlUi     = 8'h03;
    localparam logic [7:0]  PidNone    = 8'hF0;
    localparam logic [7:0]  SpaceChar  = 8'h20;
    localparam logic [7:0]  ZeroChar   = 8'h30;
    localparam logic [15:0] CrcInit    = 16'hFFFF;
    localparam logic [15:0] CrcPoly    = 16'h8408;

    typedef enum logic [1:0] {
        KIND_FLAG = 2'd0,
        KIND_ADDR = 2'd1,
        KIND_INFO = 2'd2,
        KIND_FCS  = 2'd3
    } byte_kind_t;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_DEST_CALL   = 3'd0,
        CFG_DEST_SSID   = 3'd1,
        CFG_SOURCE_CALL = 3'd2,
        CFG_SOURCE_SSID = 3'd3,
        CFG_PATH_CALL   = 3'd4,
        CFG_PATH_SSID   = 3'd5,
        CFG_PATH_ENABLE = 3'd6,
        CFG_LEAD_FLAGS  = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ADDR_DEST   = 2'd0,
        ADDR_SOURCE = 2'd1,
        ADDR_PATH   = 2'd2
    } addr_sel_t;

    // Station addresses as held by the configuration registers.
    typedef struct packed {
        logic [CallW-1:0] dest_call;
        logic [SsidW-1:0] dest_ssid;
        logic [CallW-1:0] source_call;
        logic [SsidW-1:0] source_ssid;
        logic [CallW-1:0] path_call;
        logic [SsidW-1:0] path_ssid;
        logic             path_enable;
    } addr_cfg_t;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/ax25_ui_frame_builder.sv =====
// Top level of the AX.25 UI frame builder: configuration registers, per-byte sequencer,
// running CRC-16 and the output register. Depends on ax25ui_pkg and ax25ui_addr_byte.
//
// Usage: information bytes enter on the input channel (in_valid/in_ready, data_byte,
// last_in) and framed bytes leave on the output channel (out_valid/out_ready, out_byte,
// byte_kind, last_of_run). Station addresses, the path enable and the lead flag count are
// written through the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while no
// frame byte is being worked on; cfg_ready is always high.
// Every transaction on the input produces one or more output transactions, one byte per
// cycle while out_ready is high, from a single sequencer. The first byte of a frame
// produces the lead flags (count saturated at 32), the 14 or 21 address bytes, control and
// PID, and then the data byte; a byte in the middle of a frame produces one output; the
// last byte adds the two frame check bytes and three closing flags. The first result goes
// from the item holder into the output register; the next input is taken in the cycle
// that the current item's final byte is loaded, so mid-frame bytes stream at one per cycle.
// The output register is the only buffer: when the receiver holds out_ready low the
// sequencer stops and in_ready falls once the held item still has bytes to emit.
// Reset empties both the item holder and the output register, closes any open frame,
// sets the CRC to all ones and restores the registers (path enabled, eight lead flags).
module ax25_ui_frame_builder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ax25ui_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [ax25ui_pkg::CallW-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [7:0]                            out_byte,
    output logic [1:0]                            byte_kind,
    output logic                                  last_of_run
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_ADDR,
        PH_CTRL,
        PH_PID,
        PH_INFO,
        PH_FCS_LO,
        PH_FCS_HI,
        PH_TRAIL
    } phase_t;

    ax25ui_pkg::addr_cfg_t                  cfg_reg;
    logic [ax25ui_pkg::FlagCountW-1:0]      lead_flags_reg;

    logic                                   item_valid_reg, item_valid_next;
    logic [7:0]                             item_data_reg, item_data_next;
    logic                                   item_last_reg, item_last_next;
    phase_t                                 phase_reg, phase_next;
    logic [ax25ui_pkg::FlagCountW-1:0]      cnt_reg, cnt_next;
    ax25ui_pkg::addr_sel_t                  addr_sel_reg, addr_sel_next;
    logic [2:0]                             char_pos_reg, char_pos_next;
    logic                                   frame_open_reg, frame_open_next;
    logic [15:0]                            crc_reg, crc_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [7:0]                             out_byte_reg, out_byte_next;
    ax25ui_pkg::byte_kind_t                 out_kind_reg, out_kind_next;
    logic                                   out_last_reg, out_last_next;

    logic [ax25ui_pkg::FlagCountW-1:0]      flag_limit;
    logic [ax25ui_pkg::FlagCountW-1:0]      cnt_inc;
    logic [7:0]                             addr_byte;
    logic [7:0]                             emit_byte;
    logic [15:0]                            fcs;
    logic                                   advance;
    logic                                   item_done;
    logic                                   accept;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_kind   = out_kind_reg;
    assign last_of_run = out_last_reg;

    ax25ui_addr_byte u_addr_byte (
        .cfg       (cfg_reg),
        .addr_sel  (addr_sel_reg),
        .char_pos  (char_pos_reg),
        .addr_byte (addr_byte)
    );

    // Lead flag count saturates at the maximum supported run.
    assign flag_limit = (lead_flags_reg > ax25ui_pkg::FlagCountW'(ax25ui_pkg::MaxLeadFlags))
                      ? ax25ui_pkg::FlagCountW'(ax25ui_pkg::MaxLeadFlags) : lead_flags_reg;
    assign cnt_inc    = cnt_reg + 1'b1;
    assign fcs        = ~crc_reg;

    // The sequencer moves whenever an item is held and the output register can take a byte.
    assign advance  = item_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~item_valid_reg | item_done;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        addr_sel_next   = addr_sel_reg;
        char_pos_next   = char_pos_reg;
        frame_open_next = frame_open_reg;
        crc_next        = crc_reg;
        item_valid_next = item_valid_reg;
        item_data_next  = item_data_reg;
        item_last_next  = item_last_reg;
        item_done       = 1'b0;
        emit_byte       = ax25ui_pkg::FlagByte;
        out_kind_next   = ax25ui_pkg::KIND_FLAG;
        out_last_next   = 1'b0;

        case (phase_reg)
            PH_LEAD:
            begin
                emit_byte     = ax25ui_pkg::FlagByte;
                out_kind_next = ax25ui_pkg::KIND_FLAG;
            end
            PH_ADDR:
            begin
                emit_byte     = addr_byte;
                out_kind_next = ax25ui_pkg::KIND_ADDR;
            end
            PH_CTRL:
            begin
                emit_byte     = ax25ui_pkg::CtrlUi;
                out_kind_next = ax25ui_pkg::KIND_ADDR;
            end
            PH_PID:
            begin
                emit_byte     = ax25ui_pkg::PidNone;
                out_kind_next = ax25ui_pkg::KIND_ADDR;
            end
            PH_INFO:
            begin
                emit_byte     = item_data_reg;
                out_kind_next = ax25ui_pkg::KIND_INFO;
                out_last_next = ~item_last_reg;
            end
            PH_FCS_LO:
            begin
                emit_byte     = fcs[7:0];
                out_kind_next = ax25ui_pkg::KIND_FCS;
            end
            PH_FCS_HI:
            begin
                emit_byte     = fcs[15:8];
                out_kind_next = ax25ui_pkg::KIND_FCS;
            end
            PH_TRAIL:
            begin
                emit_byte     = ax25ui_pkg::FlagByte;
                out_kind_next = ax25ui_pkg::KIND_FLAG;
                out_last_next = (cnt_reg == 6'd2);
            end
            default:
            begin
                emit_byte     = ax25ui_pkg::FlagByte;
                out_kind_next = ax25ui_pkg::KIND_FLAG;
            end
        endcase

        if (advance) begin
            case (phase_reg)
                PH_LEAD:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == flag_limit) begin
                        cnt_next   = '0;
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    crc_next      = ax25ui_pkg::crc_feed(crc_reg, emit_byte);
                    char_pos_next = char_pos_reg + 1'b1;
                    if (char_pos_reg == 3'd6) begin
                        char_pos_next = '0;
                        if (addr_sel_reg == ax25ui_pkg::ADDR_PATH ||
                            (addr_sel_reg == ax25ui_pkg::ADDR_SOURCE && !cfg_reg.path_enable))
                        begin
                            phase_next = PH_CTRL;
                        end else if (addr_sel_reg == ax25ui_pkg::ADDR_DEST) begin
                            addr_sel_next = ax25ui_pkg::ADDR_SOURCE;
                        end else begin
                            addr_sel_next = ax25ui_pkg::ADDR_PATH;
                        end
                    end
                end
                PH_CTRL:
                begin
                    crc_next   = ax25ui_pkg::crc_feed(crc_reg, emit_byte);
                    phase_next = PH_PID;
                end
                PH_PID:
                begin
                    crc_next   = ax25ui_pkg::crc_feed(crc_reg, emit_byte);
                    phase_next = PH_INFO;
                end
                PH_INFO:
                begin
                    crc_next        = ax25ui_pkg::crc_feed(crc_reg, emit_byte);
                    frame_open_next = 1'b1;
                    if (item_last_reg) begin
                        phase_next = PH_FCS_LO;
                    end else begin
                        item_done = 1'b1;
                    end
                end
                PH_FCS_LO:
                begin
                    phase_next = PH_FCS_HI;
                end
                PH_FCS_HI:
                begin
                    phase_next = PH_TRAIL;
                    cnt_next   = '0;
                end
                PH_TRAIL:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_reg == 6'd2) begin
                        item_done       = 1'b1;
                        frame_open_next = 1'b0;
                        crc_next        = ax25ui_pkg::CrcInit;
                    end
                end
                default:
                begin
                    phase_next = PH_INFO;
                end
            endcase
        end

        if (item_done) begin
            item_valid_next = 1'b0;
        end

        // A new item starts either mid-frame with its data byte or with the frame header.
        if (accept) begin
            item_valid_next = 1'b1;
            item_data_next  = data_byte;
            item_last_next  = last_in;
            cnt_next        = '0;
            addr_sel_next   = ax25ui_pkg::ADDR_DEST;
            char_pos_next   = '0;
            if (frame_open_next) begin
                phase_next = PH_INFO;
            end else begin
                crc_next   = ax25ui_pkg::CrcInit;
                phase_next = (flag_limit == '0) ? PH_ADDR : PH_LEAD;
            end
        end

        if (advance) begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
        end else begin
            out_valid_next = out_valid_reg & ~out_ready;
            out_byte_next  = out_byte_reg;
            out_kind_next  = out_kind_reg;
            out_last_next  = out_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.dest_call   <= '0;
            cfg_reg.dest_ssid   <= '0;
            cfg_reg.source_call <= '0;
            cfg_reg.source_ssid <= '0;
            cfg_reg.path_call   <= '0;
            cfg_reg.path_ssid   <= '0;
            cfg_reg.path_enable <= 1'b1;
            lead_flags_reg      <= 6'd8;
            item_valid_reg      <= 1'b0;
            item_data_reg       <= '0;
            item_last_reg       <= 1'b0;
            phase_reg           <= PH_INFO;
            cnt_reg             <= '0;
            addr_sel_reg        <= ax25ui_pkg::ADDR_DEST;
            char_pos_reg        <= '0;
            frame_open_reg      <= 1'b0;
            crc_reg             <= ax25ui_pkg::CrcInit;
            out_valid_reg       <= 1'b0;
            out_byte_reg        <= '0;
            out_kind_reg        <= ax25ui_pkg::KIND_FLAG;
            out_last_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ax25ui_pkg::CFG_DEST_CALL:   cfg_reg.dest_call   <= cfg_data;
                    ax25ui_pkg::CFG_DEST_SSID:   cfg_reg.dest_ssid   <= cfg_data[3:0];
                    ax25ui_pkg::CFG_SOURCE_CALL: cfg_reg.source_call <= cfg_data;
                    ax25ui_pkg::CFG_SOURCE_SSID: cfg_reg.source_ssid <= cfg_data[3:0];
                    ax25ui_pkg::CFG_PATH_CALL:   cfg_reg.path_call   <= cfg_data;
                    ax25ui_pkg::CFG_PATH_SSID:   cfg_reg.path_ssid   <= cfg_data[3:0];
                    ax25ui_pkg::CFG_PATH_ENABLE: cfg_reg.path_enable <= cfg_data[0];
                    ax25ui_pkg::CFG_LEAD_FLAGS:  lead_flags_reg      <= cfg_data[5:0];
                    default:                     lead_flags_reg      <= lead_flags_reg;
                endcase
            end
            item_valid_reg <= item_valid_next;
            item_data_reg  <= item_data_next;
            item_last_reg  <= item_last_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            addr_sel_reg   <= addr_sel_next;
            char_pos_reg   <= char_pos_next;
            frame_open_reg <= frame_open_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_kind_reg   <= out_kind_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

// ===== design/ax25ui_addr_byte.sv =====
// Address field byte generator: picks one of the three station addresses and forms
// its shifted callsign character or SSID byte. Depends on ax25ui_pkg.
module ax25ui_addr_byte (
    input  ax25ui_pkg::addr_cfg_t cfg,
    input  ax25ui_pkg::addr_sel_t addr_sel,
    input  logic [2:0]            char_pos,
    output logic [7:0]            addr_byte
);

    logic [ax25ui_pkg::CallW-1:0] call;
    logic [ax25ui_pkg::SsidW-1:0] ssid;
    logic                         last_addr;
    logic [7:0]                   chars [6];
    logic [5:0]                   ended;
    logic [7:0]                   ch;
    logic [7:0]                   ssid_byte;

    always_comb
    begin
        case (addr_sel)
            ax25ui_pkg::ADDR_DEST:
            begin
                call      = cfg.dest_call;
                ssid      = cfg.dest_ssid;
                last_addr = 1'b0;
            end
            ax25ui_pkg::ADDR_SOURCE:
            begin
                call      = cfg.source_call;
                ssid      = cfg.source_ssid;
                last_addr = ~cfg.path_enable;
            end
            default:
            begin
                call      = cfg.path_call;
                ssid      = cfg.path_ssid;
                last_addr = 1'b1;
            end
        endcase
    end

    // A zero character ends the callsign; it and everything after it go out as spaces.
    always_comb
    begin
        for (int i = 0; i < 6; i++) begin
            chars[i] = call[8*(5-i) +: 8];
        end
        ended[0] = (chars[0] == 8'h00);
        for (int i = 1; i < 6; i++) begin
            ended[i] = ended[i-1] | (chars[i] == 8'h00);
        end
    end

    always_comb
    begin
        ch        = 8'h00;
        ssid_byte = {{3'b000, ssid} + ax25ui_pkg::ZeroChar[6:0], last_addr};
        for (int i = 0; i < 6; i++) begin
            if (char_pos == 3'(i)) begin
                ch = ended[i] ? ax25ui_pkg::SpaceChar : chars[i];
            end
        end
        if (char_pos == 3'd6) begin
            addr_byte = ssid_byte;
        end else begin
            addr_byte = {ch[6:0], 1'b0};
        end
    end

endmodule

// ===== sim/tb_ax25_ui_frame_builder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ax25_ui_frame_builder: drives information bytes and register
// writes, predicts every framed byte and checks the output stream. Depends on ax25ui_pkg.
module tb_ax25_ui_frame_builder;

    // One information byte as offered on the input channel.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } info_item_t;

    // One framed byte as it should leave the output channel.
    typedef struct {
        logic [7:0]             value;
        ax25ui_pkg::byte_kind_t kind;
        logic                   run_end;
    } framed_byte_t;

    // Cycles to let pass after the last expected byte before touching the registers or
    // ending the run.
    localparam int SettleCycles = 8;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_valid   = 1'b0;
    logic                             cfg_ready;
    logic [ax25ui_pkg::CfgIndexW-1:0] cfg_index   = ax25ui_pkg::CFG_DEST_CALL;
    logic [ax25ui_pkg::CallW-1:0]     cfg_data    = '0;
    logic                             in_valid    = 1'b0;
    logic                             in_ready;
    logic [7:0]                       data_byte   = 8'h00;
    logic                             last_in     = 1'b0;
    logic                             out_valid;
    logic                             out_ready   = 1'b0;
    logic [7:0]                       out_byte;
    logic [1:0]                       byte_kind;
    logic                             last_of_run;

    // Stimulus backlog, filled by the sequence below and drained by the input driver.
    info_item_t   info_backlog[$];
    // Framed bytes predicted but not yet seen on the output, oldest first.
    framed_byte_t frame_bytes_due[$];
    // Scratch list for the bytes that one input transaction causes.
    framed_byte_t run_bytes[$];

    // Shadow copy of the registers and of the frame state inside the block.
    ax25ui_pkg::addr_cfg_t station_regs;
    logic [5:0]            lead_flag_reg;
    logic                  frame_in_progress;
    logic [15:0]           frame_crc;

    // Handshake flags raised at the rising edge and consumed at the falling edge.
    bit           in_taken  = 1'b0;
    bit           cfg_taken = 1'b0;

    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           items_queued   = 0;
    int           items_accepted = 0;
    int           frames_closed  = 0;
    int           bytes_checked  = 0;
    int           reg_writes     = 0;
    int           mismatch_count = 0;

    ax25_ui_frame_builder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_kind   (byte_kind),
        .last_of_run (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------------------

    // CRC-16/X.25 over one byte, shifting the data in LSB first against the reflected
    // polynomial.
    function automatic logic [15:0] crc16_x25_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] acc;
        logic        feedback;
        acc = crc;
        for (int k = 0; k < 8; k++)
        begin
            feedback = acc[0] ^ b[k];
            acc      = {1'b0, acc[15:1]};
            if (feedback)
            begin
                acc = acc ^ ax25ui_pkg::CrcPoly;
            end
        end
        return acc;
    endfunction

    function automatic void stage_byte(logic [7:0] value, ax25ui_pkg::byte_kind_t kind,
                                       bit in_crc);
        framed_byte_t entry;
        entry.value   = value;
        entry.kind    = kind;
        entry.run_end = 1'b0;
        run_bytes.push_back(entry);
        if (in_crc)
        begin
            frame_crc = crc16_x25_step(frame_crc, value);
        end
    endfunction

    // Six callsign characters shifted left, then the SSID byte. Once a zero character is
    // seen, it and everything after it go out as spaces. The extension bit marks the
    // address that closes the address field.
    function automatic void stage_address(logic [ax25ui_pkg::CallW-1:0] call,
                                          logic [ax25ui_pkg::SsidW-1:0] ssid,
                                          logic closes_field);
        logic [7:0] ch;
        logic [7:0] ssid_char;
        logic       padding;
        padding = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            ch = call[8*(5-i) +: 8];
            if (ch == 8'h00)
            begin
                padding = 1'b1;
            end
            if (padding)
            begin
                ch = ax25ui_pkg::SpaceChar;
            end
            stage_byte({ch[6:0], 1'b0}, ax25ui_pkg::KIND_ADDR, 1'b1);
        end
        ssid_char = {4'h0, ssid} + ax25ui_pkg::ZeroChar;
        stage_byte({ssid_char[6:0], closes_field}, ax25ui_pkg::KIND_ADDR, 1'b1);
    endfunction

    // Works out every framed byte that one accepted information byte causes and appends
    // them to the list of due bytes, with the run-end mark on the final one.
    function automatic void predict_frame_bytes(logic [7:0] data, logic last);
        int           flags;
        logic [15:0]  fcs;
        framed_byte_t entry;
        run_bytes.delete();
        if (!frame_in_progress)
        begin
            flags = (lead_flag_reg > ax25ui_pkg::MaxLeadFlags) ? ax25ui_pkg::MaxLeadFlags
                                                               : int'(lead_flag_reg);
            for (int f = 0; f < flags; f++)
            begin
                stage_byte(ax25ui_pkg::FlagByte, ax25ui_pkg::KIND_FLAG, 1'b0);
            end
            frame_crc = ax25ui_pkg::CrcInit;
            stage_address(station_regs.dest_call, station_regs.dest_ssid, 1'b0);
            stage_address(station_regs.source_call, station_regs.source_ssid,
                          !station_regs.path_enable);
            if (station_regs.path_enable)
            begin
                stage_address(station_regs.path_call, station_regs.path_ssid, 1'b1);
            end
            stage_byte(ax25ui_pkg::CtrlUi, ax25ui_pkg::KIND_ADDR, 1'b1);
            stage_byte(ax25ui_pkg::PidNone, ax25ui_pkg::KIND_ADDR, 1'b1);
            frame_in_progress = 1'b1;
        end
        stage_byte(data, ax25ui_pkg::KIND_INFO, 1'b1);
        if (last)
        begin
            fcs = ~frame_crc;
            stage_byte(fcs[7:0], ax25ui_pkg::KIND_FCS, 1'b0);
            stage_byte(fcs[15:8], ax25ui_pkg::KIND_FCS, 1'b0);
            for (int f = 0; f < 3; f++)
            begin
                stage_byte(ax25ui_pkg::FlagByte, ax25ui_pkg::KIND_FLAG, 1'b0);
            end
            frame_in_progress = 1'b0;
            frame_crc         = ax25ui_pkg::CrcInit;
            frames_closed++;
        end
        for (int i = 0; i < run_bytes.size(); i++)
        begin
            entry         = run_bytes[i];
            entry.run_end = (i == run_bytes.size() - 1);
            frame_bytes_due.push_back(entry);
        end
    endfunction

    // Register write as the block sees it; only the low bits of the narrow registers count.
    function automatic void apply_register(ax25ui_pkg::cfg_index_t idx,
                                           logic [ax25ui_pkg::CallW-1:0] value);
        case (idx)
            ax25ui_pkg::CFG_DEST_CALL:   station_regs.dest_call   = value;
            ax25ui_pkg::CFG_DEST_SSID:   station_regs.dest_ssid   =
                                             value[ax25ui_pkg::SsidW-1:0];
            ax25ui_pkg::CFG_SOURCE_CALL: station_regs.source_call = value;
            ax25ui_pkg::CFG_SOURCE_SSID: station_regs.source_ssid =
                                             value[ax25ui_pkg::SsidW-1:0];
            ax25ui_pkg::CFG_PATH_CALL:   station_regs.path_call   = value;
            ax25ui_pkg::CFG_PATH_SSID:   station_regs.path_ssid   =
                                             value[ax25ui_pkg::SsidW-1:0];
            ax25ui_pkg::CFG_PATH_ENABLE: station_regs.path_enable = value[0];
            ax25ui_pkg::CFG_LEAD_FLAGS:  lead_flag_reg            =
                                             value[ax25ui_pkg::FlagCountW-1:0];
            default:                     ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Reset values of the shadow state match the block's reset.
    initial
    begin
        station_regs             = '0;
        station_regs.path_enable = 1'b1;
        lead_flag_reg            = 6'd8;
        frame_in_progress        = 1'b0;
        frame_crc                = ax25ui_pkg::CrcInit;
    end

    // ------------------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the block updates.
    // ------------------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        framed_byte_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_register(ax25ui_pkg::cfg_index_t'(cfg_index), cfg_data);
                cfg_taken = 1'b1;
                reg_writes++;
            end
            if (out_valid && out_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    report_mismatch($sformatf("byte %02h kind %0d with nothing expected",
                                              out_byte, byte_kind));
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (out_byte !== want.value)
                    begin
                        report_mismatch($sformatf("byte #%0d: out_byte %02h, expected %02h",
                                                  bytes_checked, out_byte, want.value));
                    end
                    if (byte_kind !== want.kind)
                    begin
                        report_mismatch($sformatf("byte #%0d: byte_kind %0d, expected %s",
                                                  bytes_checked, byte_kind, want.kind.name()));
                    end
                    if (last_of_run !== want.run_end)
                    begin
                        report_mismatch($sformatf("byte #%0d: last_of_run %0b, expected %0b",
                                                  bytes_checked, last_of_run, want.run_end));
                    end
                end
                bytes_checked++;
            end
            // The prediction is made when the information byte is taken; its first framed
            // byte cannot appear before the next edge.
            if (in_valid && in_ready)
            begin
                predict_frame_bytes(data_byte, last_in);
                in_taken = 1'b1;
                items_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Input driver and receiver: both change their outputs at the falling edge only.
    // ------------------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_info_bytes
        info_item_t next_item;
        // A new transaction is offered only once the previous one has been taken, so the
        // payload never moves under a pending valid. Each signal is assigned once here.
        if (rst_n && (!in_valid || in_taken))
        begin
            if (info_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = info_backlog.pop_front();
                in_valid  <= 1'b1;
                data_byte <= next_item.data;
                last_in   <= next_item.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------------------
    task automatic queue_item(logic [7:0] data, logic last);
        info_item_t item;
        item.data = data;
        item.last = last;
        info_backlog.push_back(item);
        items_queued++;
    endtask

    // Waits until every queued byte is taken and every predicted byte has come out, then
    // leaves the block quiet for SettleCycles.
    task automatic wait_until_drained();
        while (items_accepted != items_queued || frame_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_register(ax25ui_pkg::cfg_index_t idx,
                                  logic [ax25ui_pkg::CallW-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_taken)
        begin
            @(negedge clk);
        end
        cfg_taken = 1'b0;
        cfg_valid <= 1'b0;
    endtask

    // Mostly letters and digits, with zero characters to cut the callsign short and the
    // occasional byte above 0x7F.
    function automatic logic [ax25ui_pkg::CallW-1:0] random_callsign();
        logic [ax25ui_pkg::CallW-1:0] call;
        int                           pick;
        for (int i = 0; i < 6; i++)
        begin
            pick = $urandom_range(9);
            if (pick < 5)
            begin
                call[8*i +: 8] = 8'(8'h41 + $urandom_range(25));
            end
            else if (pick < 7)
            begin
                call[8*i +: 8] = 8'(ax25ui_pkg::ZeroChar + $urandom_range(9));
            end
            else if (pick == 7)
            begin
                call[8*i +: 8] = 8'h00;
            end
            else
            begin
                call[8*i +: 8] = 8'($urandom_range(255));
            end
        end
        return call;
    endfunction

    // Rewrites every register. Narrow registers get random upper bits that the block has
    // to ignore.
    task automatic random_station_setup();
        logic [ax25ui_pkg::CallW-1:0] junk;
        int                           pick;
        junk[47:32] = 16'($urandom());
        junk[31:0]  = $urandom();
        write_register(ax25ui_pkg::CFG_DEST_CALL, random_callsign());
        write_register(ax25ui_pkg::CFG_DEST_SSID, {junk[47:4], 4'($urandom_range(15))});
        write_register(ax25ui_pkg::CFG_SOURCE_CALL, random_callsign());
        write_register(ax25ui_pkg::CFG_SOURCE_SSID, {junk[46:3], 4'($urandom_range(15))});
        write_register(ax25ui_pkg::CFG_PATH_CALL, random_callsign());
        write_register(ax25ui_pkg::CFG_PATH_SSID, {junk[45:2], 4'($urandom_range(15))});
        write_register(ax25ui_pkg::CFG_PATH_ENABLE, {junk[47:1], 1'($urandom_range(1))});
        // Short lead-ins keep most frames brief; some hit or pass the saturation point.
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            write_register(ax25ui_pkg::CFG_LEAD_FLAGS, {junk[47:6], 6'($urandom_range(6))});
        end
        else if (pick < 8)
        begin
            write_register(ax25ui_pkg::CFG_LEAD_FLAGS,
                           {junk[47:6], 6'($urandom_range(32, 7))});
        end
        else
        begin
            write_register(ax25ui_pkg::CFG_LEAD_FLAGS,
                           {junk[47:6], 6'($urandom_range(63, 33))});
        end
    endtask

    // Frames of random length and content. Most are closed; an unclosed one left at the
    // end of a batch carries an open frame across the next register writes.
    task automatic queue_random_frames(int target);
        int count;
        int len;
        int pick;
        bit close;
        count = 0;
        while (count < target)
        begin
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                len = 1;
            end
            else if (pick < 8)
            begin
                len = $urandom_range(6, 2);
            end
            else
            begin
                len = $urandom_range(20, 7);
            end
            close = ($urandom_range(9) != 0);
            for (int i = 0; i < len; i++)
            begin
                queue_item(8'($urandom_range(255)), close && (i == len - 1));
            end
            count += len;
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 62;

        // Reset registers: all-zero callsigns go out as spaces, path on, eight flags.
        // A three-byte frame with extreme data, then a frame of a single byte.
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h55, 1'b1);
        queue_item(8'hAA, 1'b1);
        wait_until_drained();

        // Zero characters in the middle of the destination, characters above 0x7F in the
        // source, no path and no lead flags.
        write_register(ax25ui_pkg::CFG_DEST_CALL, 48'h41_42_00_43_44_00);
        write_register(ax25ui_pkg::CFG_DEST_SSID, 48'h0000_0000_000F);
        write_register(ax25ui_pkg::CFG_SOURCE_CALL, 48'h80_FF_C1_7F_01_20);
        write_register(ax25ui_pkg::CFG_SOURCE_SSID, 48'hFFFF_FFFF_FFF0);
        write_register(ax25ui_pkg::CFG_PATH_ENABLE, 48'h0000_0000_0000);
        write_register(ax25ui_pkg::CFG_LEAD_FLAGS, 48'h0000_0000_0000);
        queue_item(8'h01, 1'b0);
        queue_item(8'h80, 1'b1);
        queue_item(8'h7E, 1'b1);
        // This frame stays open while the registers change below.
        queue_item(8'h00, 1'b0);
        wait_until_drained();

        // Written while a frame is open: the open frame keeps its address field and only
        // the next frame picks up the path and the saturated flag count.
        write_register(ax25ui_pkg::CFG_PATH_CALL, 48'hFFFF_FFFF_FFFF);
        write_register(ax25ui_pkg::CFG_PATH_SSID, 48'h0000_0000_000F);
        write_register(ax25ui_pkg::CFG_PATH_ENABLE, 48'h0000_0000_0001);
        write_register(ax25ui_pkg::CFG_LEAD_FLAGS, 48'h0000_0000_003F);
        queue_item(8'hC3, 1'b1);
        queue_item(8'h3C, 1'b1);
        wait_until_drained();

        // Flag counts right at and just past the saturation point, then a single flag. The
        // path enable write carries ones above bit 0 but disables the path.
        write_register(ax25ui_pkg::CFG_LEAD_FLAGS, 48'd32);
        queue_item(8'h5A, 1'b1);
        wait_until_drained();
        write_register(ax25ui_pkg::CFG_LEAD_FLAGS, 48'd33);
        queue_item(8'hA5, 1'b1);
        wait_until_drained();
        write_register(ax25ui_pkg::CFG_LEAD_FLAGS, 48'd1);
        write_register(ax25ui_pkg::CFG_PATH_ENABLE, 48'hFFFF_FFFF_FFFE);
        queue_item(8'h0F, 1'b0);
        queue_item(8'hF0, 1'b1);
        wait_until_drained();

        // Random batches, each under fresh register values, through three idle mixes.
        for (int batch = 0; batch < 6; batch++)
        begin
            if (batch == 2)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 24;
            end
            else if (batch == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_station_setup();
            queue_random_frames(15);
            wait_until_drained();
        end
        repeat (20) @(negedge clk);

        $display("Covered %0d information bytes in %0d closed frames, %0d framed bytes checked.",
                 items_accepted, frames_closed, bytes_checked);
        $display("%0d register writes: flag counts 0 to 63, path on and off, odd characters.",
                 reg_writes);
        if (mismatch_count == 0 && frame_bytes_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d framed bytes never seen",
                     mismatch_count, frame_bytes_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: the slowest correct run is far below this.
    initial
    begin
        #400000;
        $display("Timeout with %0d framed bytes still due", frame_bytes_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
